[sv/greedy_max_cut_partition_assert.svh]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner assertion macros
// Clocked, reset-qualified property wrappers used by the top level.
// ---------------------------------------------------------------------------
`ifndef GREEDY_MAX_CUT_PARTITION_ASSERT_SVH
`define GREEDY_MAX_CUT_PARTITION_ASSERT_SVH

// Property holds at every edge outside reset.
`define GMC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Trigger at one edge implies consequence at the next.
`define GMC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/gmc_pkg.sv]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner package
// Beat types, fixed field widths and the cell control bundle.
// ---------------------------------------------------------------------------
package gmc_pkg;

  localparam int unsigned ROW_W = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CUT_W = 11;
  localparam logic [CUT_W-1:0] CUT_SAT = {CUT_W{1'b1}};

  typedef struct packed {
    logic [ROW_W-1:0] neighbor_row;
    logic             last_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             side;
    logic [IDX_W-1:0] edges_cut;
    logic [CUT_W-1:0] cut_total;
    logic             graph_done;
  } out_beat_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic accept;  // a vertex is placed this cycle
    logic clear;   // graph ends: drop all placements
    logic side;    // side chosen for the vertex being placed
  } cell_ctrl_t;

endpackage

[sv/gmc_cell.sv]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner cell
// Holds one vertex slot; a one-hot write token walks the row one cell per beat.
// ---------------------------------------------------------------------------
module gmc_cell import gmc_pkg::*; #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       token_i,
  input  logic       row_bit_i,
  output logic       token_o,
  output logic       ones_o,
  output logic       zeros_o
);

  logic token_q, token_d;
  logic placed_q, placed_d;
  logic side_q, side_d;

  always_comb begin
    token_d  = token_q;
    placed_d = placed_q;
    side_d   = side_q;
    if (ctrl_i.clear) begin
      token_d  = IS_FIRST;
      placed_d = 1'b0;
      side_d   = 1'b0;
    end else if (ctrl_i.accept) begin
      token_d = token_i;
      if (token_q) begin
        placed_d = 1'b1;
        side_d   = ctrl_i.side;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= IS_FIRST;
      placed_q <= 1'b0;
      side_q   <= 1'b0;
    end else begin
      token_q  <= token_d;
      placed_q <= placed_d;
      side_q   <= side_d;
    end
  end

  assign token_o = token_q;
  assign ones_o  = row_bit_i & placed_q & side_q;
  assign zeros_o = row_bit_i & placed_q & ~side_q;

endmodule

[sv/gmc_popcount.sv]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner popcount
// Balanced adder tree over the per-cell neighbor flags.
// ---------------------------------------------------------------------------
module gmc_popcount #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0]             bits_i,
  output logic [$clog2(N+1)-1:0]   count_o
);

  localparam int unsigned LVL = $clog2(N);
  localparam int unsigned P   = 1 << LVL;
  localparam int unsigned CW  = $clog2(N + 1);

  // Heap-ordered tree: node 1 is the root, leaves start at P.
  logic [CW-1:0] node [1:2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign node[P+i] = CW'(bits_i[i]);
    end else begin : g_pad
      assign node[P+i] = '0;
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_sum
    assign node[k] = CW'(node[2*k] + node[2*k+1]);
  end

  assign count_o = node[1];

endmodule

[sv/greedy_max_cut_partition.sv]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner
// Registered: a result beat appears the cycle after its vertex is accepted.
// Throughput: one vertex per cycle unless stalled; the popcount tree over
//   the cell row and the side bit fed back to the token cell close within it.
// Reset: asynchronous, active low; clears all placements, the vertex index,
//   the running cut and the output valid. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "greedy_max_cut_partition_assert.svh"

module greedy_max_cut_partition import gmc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output out_beat_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  // Handshake: the output register refills in the same cycle it drains, so
  // the input only stalls while a result beat is held by downstream.
  logic accept;
  logic out_valid_q;
  out_beat_t out_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Cell row. token[v] marks the slot that the incoming vertex will occupy;
  // token[0] therefore means "first vertex of the graph", and the last cell
  // holding the token means the row is full and this vertex ends the graph.
  logic [MAX_VERTICES-1:0] token;
  logic [MAX_VERTICES-1:0] ones_bits;
  logic [MAX_VERTICES-1:0] zeros_bits;
  cell_ctrl_t ctrl;

  logic first_vtx;
  logic last_vtx;
  logic new_side;

  assign first_vtx = token[0];
  assign last_vtx  = in_data_i.last_vertex | token[MAX_VERTICES-1];

  assign ctrl.accept = accept;
  assign ctrl.clear  = accept & last_vtx;
  assign ctrl.side   = new_side;

  for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_cell
    logic tok_in;
    if (v == 0) begin : g_head
      assign tok_in = 1'b0;
    end else begin : g_link
      assign tok_in = token[v-1];
    end

    gmc_cell #(
      .IS_FIRST (v == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .token_i   (tok_in),
      .row_bit_i (in_data_i.neighbor_row[v]),
      .token_o   (token[v]),
      .ones_o    (ones_bits[v]),
      .zeros_o   (zeros_bits[v])
    );
  end

  // Earlier neighbors on each side. Cells that are not yet placed contribute
  // nothing, which masks self and forward edges.
  logic [CNT_W-1:0] ones_cnt;
  logic [CNT_W-1:0] zeros_cnt;

  gmc_popcount #(.N(MAX_VERTICES)) u_pop_ones (
    .bits_i  (ones_bits),
    .count_o (ones_cnt)
  );

  gmc_popcount #(.N(MAX_VERTICES)) u_pop_zeros (
    .bits_i  (zeros_bits),
    .count_o (zeros_cnt)
  );

  // Go opposite the majority; a tie lands on side 1, the first vertex on 0.
  assign new_side = first_vtx ? 1'b0 : ~(ones_cnt > zeros_cnt);

  logic [IDX_W-1:0] cut;
  assign cut = new_side ? IDX_W'(zeros_cnt) : IDX_W'(ones_cnt);

  // Running cut, saturating (cannot actually reach the limit).
  logic [CUT_W-1:0] running_q, running_d;
  logic [CUT_W:0]   run_sum;
  logic [CUT_W-1:0] run_next;

  assign run_sum  = {1'b0, running_q} + (CUT_W + 1)'(cut);
  assign run_next = run_sum[CUT_W] ? CUT_SAT : run_sum[CUT_W-1:0];

  logic [IDX_W-1:0] idx_q, idx_d;

  always_comb begin
    idx_d     = idx_q;
    running_d = running_q;
    if (accept) begin
      if (last_vtx) begin
        idx_d     = '0;
        running_d = '0;
      end else begin
        idx_d     = idx_q + IDX_W'(1);
        running_d = run_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      running_q <= '0;
    end else begin
      idx_q     <= idx_d;
      running_q <= running_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.vertex_index <= idx_q;
      out_q.side         <= new_side;
      out_q.edges_cut    <= cut;
      out_q.cut_total    <= run_next;
      out_q.graph_done   <= last_vtx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks.
  `GMC_ASSERT_ALWAYS(a_token_onehot, $onehot(token), "write token not one-hot")
  `GMC_ASSERT_NEXT(a_graph_restart, accept && last_vtx,
                   token[0] && idx_q == '0 && running_q == '0,
                   "state not cleared after last vertex")
  `GMC_ASSERT_ALWAYS(a_cut_bound,
                     !out_valid_o || out_data_o.edges_cut <= out_data_o.vertex_index,
                     "edges cut exceeds earlier vertex count")

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// Greedy max-cut partitioner testbench
// Sends graphs one vertex beat at a time and checks every result beat against
// a cycle-free model of the greedy placement. Covers directed corner graphs
// and random graphs of mixed size and density, including full 64-vertex graphs
// that hit the vertex cap. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import gmc_pkg::*;

  localparam int unsigned MAX_VERTICES  = 64;
  localparam int unsigned VERTEX_TARGET = 1600;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [IDX_W-1:0] CAP_INDEX = IDX_W'(MAX_VERTICES - 1);
  localparam logic [ROW_W-1:0] ROW_FULL_MASK = '1;
  localparam int unsigned CUT_CEIL = (1 << CUT_W) - 1;

  // Shapes of neighbor rows used by the random graphs.
  typedef enum int unsigned {
    ROW_RANDOM,
    ROW_SPARSE,
    ROW_DENSE,
    ROW_FULL,
    ROW_EMPTY
  } row_style_e;

  // -------------------------------------------------------------------------
  // Placement model and result checker.
  // Tracks the side of every placed vertex, the next vertex index and the
  // running cut; each accepted vertex pushes the result it must produce.
  // -------------------------------------------------------------------------
  class cut_scoreboard;
    out_beat_t        placements_q[$];
    logic [ROW_W-1:0] side_map;
    logic [IDX_W-1:0] vertex_no;
    int unsigned      cut_sum;
    int unsigned      errors;
    int unsigned      results_checked;
    int unsigned      graphs_closed;
    int unsigned      capped_graphs;
    int unsigned      peak_cut;

    function new();
      side_map        = '0;
      vertex_no       = '0;
      cut_sum         = 0;
      errors          = 0;
      results_checked = 0;
      graphs_closed   = 0;
      capped_graphs   = 0;
      peak_cut        = 0;
    endfunction

    function int unsigned pending();
      return placements_q.size();
    endfunction

    // Place one accepted vertex and queue the result it causes.
    function void note_vertex(in_beat_t beat);
      logic [ROW_W-1:0] earlier_mask;
      logic [ROW_W-1:0] row;
      int unsigned      on_one;
      int unsigned      on_zero;
      int unsigned      cut_now;
      bit               ends;
      out_beat_t        want;

      // only edges to earlier vertices count; vertex 0 sees none
      earlier_mask = (ROW_W'(1) << vertex_no) - ROW_W'(1);
      row     = beat.neighbor_row & earlier_mask;
      on_one  = $countones(row & side_map);
      on_zero = $countones(row & ~side_map);

      // vertex 0 goes to side 0; otherwise side 0 only on a strict majority of
      // side-1 neighbors, so ties land on side 1
      want.vertex_index = vertex_no;
      want.side         = (vertex_no != '0) && (on_one <= on_zero);
      cut_now           = want.side ? on_zero : on_one;
      want.edges_cut    = IDX_W'(cut_now);
      cut_sum           = cut_sum + cut_now;
      if (cut_sum > CUT_CEIL) cut_sum = CUT_CEIL;
      want.cut_total    = CUT_W'(cut_sum);
      ends              = beat.last_vertex || (vertex_no == CAP_INDEX);
      want.graph_done   = ends;
      placements_q.push_back(want);

      if (cut_sum > peak_cut) peak_cut = cut_sum;
      if (want.side) side_map[vertex_no] = 1'b1;
      if (ends) begin
        graphs_closed++;
        if (!beat.last_vertex) capped_graphs++;
        side_map  = '0;
        vertex_no = '0;
        cut_sum   = 0;
      end else begin
        vertex_no = vertex_no + 1'b1;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(out_beat_t got);
      out_beat_t want;
      if (placements_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, actual %p", $time, got);
        return;
      end
      want = placements_q.pop_front();
      results_checked++;
      compare_field("vertex_index", want.vertex_index, got.vertex_index);
      compare_field("side", want.side, got.side);
      compare_field("edges_cut", want.edges_cut, got.edges_cut);
      compare_field("cut_total", want.cut_total, got.cut_total);
      compare_field("graph_done", want.graph_done, got.graph_done);
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // -------------------------------------------------------------------------
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  in_beat_t  in_data_i   = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  out_beat_t out_data_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;

  cut_scoreboard sb;
  int unsigned   vertices_sent = 0;
  bit            src_burst     = 1'b0;  // no gaps between beats of this graph
  int unsigned   sink_run      = 0;
  logic          sink_hold     = 1'b0;
  int unsigned   sink_pick;

  greedy_max_cut_partition #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure: runs of no stall, short stalls, rare long ones.
  always @(posedge clk_i) begin
    if (sink_run == 0) begin
      sink_pick = $urandom_range(99);
      if (sink_pick < 50) begin
        sink_hold = 1'b0;
        sink_run  = $urandom_range(30, 1);
      end else if (sink_pick < 92) begin
        sink_hold = 1'b1;
        sink_run  = $urandom_range(3, 1);
      end else begin
        sink_hold = 1'b1;
        sink_run  = $urandom_range(40, 10);
      end
    end
    sink_run--;
    out_stall_i <= sink_hold;
  end

  // Outputs are sampled mid-cycle, where they are stable. stall only moves at
  // the rising edge, so a beat seen valid and unstalled here is accepted at
  // the next edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results still expected", CYCLE_LIMIT,
             sb.pending());
    $display("FAILURE");
    $finish;
  end

  // Offer one vertex beat after a random gap and hold it until accepted.
  task automatic send_vertex(input logic [ROW_W-1:0] row, input logic last);
    int unsigned pick;
    int unsigned gap;
    bit          taken;
    in_beat_t    beat;
    pick = $urandom_range(99);
    if (src_burst || pick < 60) gap = 0;
    else if (pick < 93) gap = $urandom_range(3, 1);
    else gap = $urandom_range(30, 10);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    beat.neighbor_row = row;
    beat.last_vertex  = last;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_vertex(beat);
    vertices_sent++;
  endtask

  // Stop sending until every queued result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Corner graphs, worked by hand.
  task automatic directed_graphs();
    // vertex 0 ignores every row bit and goes to side 0
    send_vertex(ROW_FULL_MASK, 1'b0);
    // no neighbors: tie goes to side 1
    send_vertex('0, 1'b0);
    // one neighbor on each side: tie, side 1, cuts the side-0 edge
    send_vertex(ROW_FULL_MASK, 1'b0);
    // both neighbors on side 1: side 0, cuts both
    send_vertex(64'h6, 1'b0);
    // two per side plus forward bits that must be ignored
    send_vertex(ROW_FULL_MASK, 1'b0);
    // only the top bit set, which is a forward edge; graph ends here
    send_vertex(64'h8000_0000_0000_0000, 1'b1);
    // single-vertex graph
    send_vertex(ROW_FULL_MASK, 1'b1);
    // two vertices joined by one edge
    send_vertex('0, 1'b0);
    send_vertex(64'h1, 1'b1);
    // majority of side-1 neighbors pulls the vertex to side 0
    send_vertex('0, 1'b0);
    send_vertex('0, 1'b0);
    send_vertex(64'h2, 1'b1);
  endtask

  // One graph of random size and row shape; full-size graphs may omit the
  // last flag so that the vertex cap closes them.
  task automatic random_graph();
    int unsigned      pick;
    int unsigned      size;
    row_style_e       style;
    logic [ROW_W-1:0] row;
    logic             last;
    pick = $urandom_range(99);
    if (pick < 80) size = $urandom_range(12, 1);
    else if (pick < 92) size = $urandom_range(40, 13);
    else size = MAX_VERTICES;
    style     = row_style_e'($urandom_range(ROW_EMPTY));
    src_burst = ($urandom_range(3) == 0);
    for (int unsigned k = 0; k < size; k++) begin
      case (style)
        ROW_RANDOM: row = {$urandom, $urandom};
        ROW_SPARSE: row = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        ROW_DENSE:  row = {$urandom, $urandom} | {$urandom, $urandom};
        ROW_FULL:   row = ROW_FULL_MASK;
        default:    row = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
      endcase
      if (k != size - 1) last = 1'b0;
      else if (size == MAX_VERTICES) last = 1'($urandom_range(1));
      else last = 1'b1;
      send_vertex(row, last);
    end
    src_burst = 1'b0;
  endtask

  initial begin
    int unsigned graph_no;
    sb = new();
    graph_no = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_graphs();
    drain_results();

    while (vertices_sent < VERTEX_TARGET) begin
      random_graph();
      graph_no++;
      // source holds off until the block has emptied, at least once
      if (graph_no == 40 || $urandom_range(14) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d vertices over %0d graphs, %0d of them closed by the vertex cap.",
             vertices_sent, sb.graphs_closed, sb.capped_graphs);
    $display("Checked %0d result beats; peak running cut %0d; %0d mismatches.",
             sb.results_checked, sb.peak_cut, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/gmc_pkg.sv
sv/gmc_cell.sv
sv/gmc_popcount.sv
sv/greedy_max_cut_partition.sv
verif/tb_top.sv
